>>> design/sjf_pkg.sv
package sjf_pkg;

    // Capacity of the job store
    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // Field widths
    localparam int ID_W    = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 21;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Stream payload widths, padded to whole bytes
    localparam int IN_BITS  = ID_W + ARR_W + BURST_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ID_W + ARR_W + BURST_W + 3 * TIME_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // One stored job, id in the lowest bits
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arrival;
        logic [ID_W-1:0]    id;
    } t_job;

    // Best candidate found so far by the scan
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        t_job             job;
    } t_cand;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic             clear;
        logic             vld;
        logic             done;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

endpackage

>>> design/sjf_nonpreemptive_scheduler_unit.sv
// Channel   Dir  Handshake              Payload (lowest bit first)
// s_axis    in   tvalid/tready, tlast   tdata: job_id, arrival_time, burst_time; tlast: last_job
// m_axis    out  tvalid/tready, tlast   tdata: out_job_id, out_arrival, out_burst,
//                                       completion_time, waiting_time, turnaround_time;
//                                       tlast: last_result; tuser: jobs_dropped
//
// Loading accepts one job per cycle. After the tlast transfer each result takes one pass
// over the n stored jobs through the job store's single read port, then a drain state,
// a pick state and an emit state that forms the result.
// Reset is synchronous, active low; the store contents are not cleared.
// s_axis_tready is low from the tlast transfer until the final result enters the
// output register; a stalled m_axis holds the sequencer before each result.
module sjf_nonpreemptive_scheduler_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sjf_pkg::IN_W-1:0]   s_axis_tdata,   // job_id, arrival_time, burst_time
    input  logic                       s_axis_tlast,   // last_job
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [sjf_pkg::OUT_W-1:0]  m_axis_tdata,   // id, arrival, burst, completion,
                                                       // waiting, turnaround
    output logic                       m_axis_tlast,   // last_result
    output logic                       m_axis_tuser    // jobs_dropped
);
    import sjf_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_over;
    logic [IDX_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_k;
    logic [TIME_W-1:0]   r_time;
    logic [MAX_JOBS-1:0] r_done;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    t_job                r_sel;
    logic [TIME_W-1:0]   r_comp;
    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out_data;
    logic                r_out_last;
    logic                r_out_drop;

    t_job                w_in_job;
    t_job                w_rd_job;
    logic                w_in_xfer;
    logic                w_has_room;
    logic                w_last_addr;
    logic                w_last_res;
    logic                w_out_free;
    logic                w_emit;
    t_scan_ctl           w_ctl;
    t_cand               w_elig;
    t_cand               w_fut;
    t_cand               w_win;
    logic [TIME_W-1:0]   w_start;
    logic [TIME_W:0]     w_sum;
    logic [TIME_W-1:0]   w_comp;
    logic [TIME_W-1:0]   w_turn;
    logic [TIME_W-1:0]   w_wait;
    logic [TIME_W-1:0]   w_burst_x;

    assign w_in_job    = t_job'(s_axis_tdata[IN_BITS-1:0]);
    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_has_room  = r_count < CNT_W'(MAX_JOBS);
    assign w_last_addr = {1'b0, r_addr} == (r_count - 1'b1);
    assign w_last_res  = r_k == (r_count - 1'b1);
    assign w_out_free  = !r_out_vld || m_axis_tready;
    assign w_emit      = (r_state == ST_EMIT) && w_out_free;

    sjf_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_xfer && w_has_room),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_in_job),
        .i_raddr (r_addr),
        .o_rdata (w_rd_job)
    );

    // Clear the scan on every entry to a new pass
    assign w_ctl.clear = (r_state == ST_LOAD && w_in_xfer && s_axis_tlast)
                      || (r_state == ST_EMIT && w_out_free && !w_last_res);
    assign w_ctl.vld   = r_rd_vld;
    assign w_ctl.done  = r_done[r_rd_idx];
    assign w_ctl.idx   = r_rd_idx;

    sjf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_job   (w_rd_job),
        .i_time  (r_time),
        .o_elig  (w_elig),
        .o_fut   (w_fut)
    );

    // Pick: idle forward to the earliest arrival when nothing has arrived
    assign w_win   = w_elig.found ? w_elig : w_fut;
    assign w_start = w_elig.found ? r_time
                                  : {{(TIME_W - ARR_W){1'b0}}, w_fut.job.arrival};
    assign w_sum   = {1'b0, w_start} + {{(TIME_W + 1 - BURST_W){1'b0}}, w_win.job.burst};
    assign w_comp  = (w_sum > {1'b0, TIME_MAX}) ? TIME_MAX : w_sum[TIME_W-1:0];

    // Result times; waiting floors at zero once completion has saturated
    assign w_burst_x = {{(TIME_W - BURST_W){1'b0}}, r_sel.burst};
    assign w_turn    = r_comp - {{(TIME_W - ARR_W){1'b0}}, r_sel.arrival};
    assign w_wait    = (w_turn >= w_burst_x) ? (w_turn - w_burst_x) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_over    <= 1'b0;
            r_addr    <= '0;
            r_k       <= '0;
            r_time    <= '0;
            r_done    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_SCAN);
            r_rd_idx <= r_addr;
            // Fill the output register, or empty it on a result transfer
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    // Store the job, or drop it and note the loss when full
                    if (w_in_xfer) begin
                        if (w_has_room) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_over <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_addr  <= '0;
                            r_k     <= '0;
                            r_time  <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // Walk the store once
                    if (w_last_addr) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_PICK;
                end
                ST_PICK: begin
                    r_sel             <= w_win.job;
                    r_comp            <= w_comp;
                    r_time            <= w_comp;
                    r_done[w_win.idx] <= 1'b1;
                    r_state           <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Hand over the result once the output register is free
                    if (w_out_free) begin
                        r_out_data <= OUT_W'({w_turn, w_wait, r_comp, r_sel});
                        r_out_last <= w_last_res;
                        r_out_drop <= r_over;
                        if (w_last_res) begin
                            r_count <= '0;
                            r_over  <= 1'b0;
                            r_time  <= '0;
                            r_done  <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_addr  <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

endmodule

>>> design/sjf_store.sv
module sjf_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [sjf_pkg::IDX_W-1:0] i_waddr,
    input  sjf_pkg::t_job             i_wdata,
    input  logic [sjf_pkg::IDX_W-1:0] i_raddr,
    output sjf_pkg::t_job             o_rdata
);
    import sjf_pkg::*;

    t_job r_mem [MAX_JOBS];
    t_job r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sjf_scan.sv
module sjf_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sjf_pkg::t_scan_ctl         i_ctl,
    input  sjf_pkg::t_job              i_job,
    input  logic [sjf_pkg::TIME_W-1:0] i_time,
    output sjf_pkg::t_cand             o_elig,
    output sjf_pkg::t_cand             o_fut
);
    import sjf_pkg::*;

    t_cand r_elig;
    t_cand r_fut;
    t_cand n_elig;
    t_cand n_fut;
    logic  w_arrived;
    logic  w_elig_better;
    logic  w_fut_better;

    assign w_arrived = {{(TIME_W - ARR_W){1'b0}}, i_job.arrival} <= i_time;

    // Arrived jobs: shortest burst, then earliest arrival, then lowest index
    assign w_elig_better = !r_elig.found
        || (i_job.burst < r_elig.job.burst)
        || ((i_job.burst == r_elig.job.burst) && (i_job.arrival < r_elig.job.arrival));

    // Jobs not yet arrived: earliest arrival, then shortest burst, then lowest index
    assign w_fut_better = !r_fut.found
        || (i_job.arrival < r_fut.job.arrival)
        || ((i_job.arrival == r_fut.job.arrival) && (i_job.burst < r_fut.job.burst));

    always_comb begin
        n_elig = r_elig;
        n_fut  = r_fut;
        if (i_ctl.clear) begin
            n_elig.found = 1'b0;
            n_fut.found  = 1'b0;
        end else if (i_ctl.vld && !i_ctl.done) begin
            if (w_arrived && w_elig_better) begin
                n_elig = '{found: 1'b1, idx: i_ctl.idx, job: i_job};
            end
            if (!w_arrived && w_fut_better) begin
                n_fut = '{found: 1'b1, idx: i_ctl.idx, job: i_job};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elig.found <= 1'b0;
            r_fut.found  <= 1'b0;
        end else begin
            r_elig.found <= n_elig.found;
            r_fut.found  <= n_fut.found;
        end
        r_elig.idx <= n_elig.idx;
        r_elig.job <= n_elig.job;
        r_fut.idx  <= n_fut.idx;
        r_fut.job  <= n_fut.job;
    end

    assign o_elig = r_elig;
    assign o_fut  = r_fut;

endmodule

>>> design/sjf_chk.sv
module sjf_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [sjf_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      s_axis_tlast,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [sjf_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tlast,
    input logic                      m_axis_tuser
);
    import sjf_pkg::*;

    // No result is offered right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // A closing job starts scheduling: no input is taken next cycle
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken during scheduling");

    // A non-final result is on the output: the block is still busy with its set
    a_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken before the set was finished");

endmodule

bind sjf_nonpreemptive_scheduler_unit sjf_chk u_chk (.*);
